// ===== sv/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg: shared types and constants of the delta list timer queue
// Holds the queue depth, status codes and the word that travels along the
// row of queue cells during an insertion.
// ----------------------------------------------------------------------------
`default_nettype none

package dltq_pkg;

   // number of queue cells
   localparam int QUEUE_DEPTH = 16;
   // width of a fill count that can hold QUEUE_DEPTH itself
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // result status codes
   localparam logic [1:0] ST_POSTED  = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_IDLE    = 2'd2;
   localparam logic [1:0] ST_DELIVER = 2'd3;

   // word handed from one cell to the next during an insertion
   typedef struct packed {
      logic        valid;   // word present at this cell
      logic        append;  // delay-less post: go to the tail unchanged
      logic        shift;   // slot found, now moving displaced entries down
      logic [31:0] delta;
      logic [31:0] tag;
   } tok_type;

endpackage

`default_nettype wire

// ===== sv/dltq_cell.sv =====
// ----------------------------------------------------------------------------
// dltq_cell: one entry of the delta list
// Holds a delta and a tag. An insertion word passes through one cell per
// cycle: it searches, drops its entry into place, then ripples the displaced
// entries down the row. A pop loads the entry of the right-hand neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module dltq_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    occ,        // cell holds a live entry
   input  wire dltq_pkg::tok_type tok_in,
   output dltq_pkg::tok_type      tok_out,
   input  wire                    pop_en,
   input  wire  [31:0]            pop_delta,
   input  wire  [31:0]            pop_tag,
   output logic [31:0]            delta,
   output logic [31:0]            tag
);

   logic [31:0]       delta_ff, delta_in;
   logic [31:0]       tag_ff, tag_in;
   dltq_pkg::tok_type tok_ff, tok_in_nxt;
   logic              stop;

   // search stops at the tail or at the first larger delta
   assign stop = !occ || (!tok_in.append && ($signed(tok_in.delta) < $signed(delta_ff)));

   // cell update and outgoing word
   always_comb begin
      delta_in   = delta_ff;
      tag_in     = tag_ff;
      tok_in_nxt = '0;
      if (tok_in.valid) begin
         if (!tok_in.shift && !stop) begin
            // pass by this entry
            tok_in_nxt = tok_in;
            if (!tok_in.append) begin
               tok_in_nxt.delta = tok_in.delta - delta_ff;
            end
         end else begin
            // take the incoming entry, push ours down
            delta_in = tok_in.delta;
            tag_in   = tok_in.tag;
            if (occ) begin
               tok_in_nxt.valid = 1'b1;
               tok_in_nxt.shift = 1'b1;
               tok_in_nxt.tag   = tag_ff;
               tok_in_nxt.delta = tok_in.shift ? delta_ff : (delta_ff - tok_in.delta);
            end
         end
      end else if (pop_en) begin
         delta_in = pop_delta;
         tag_in   = pop_tag;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      tag_ff   <= tag_in;
   end

   // word register toward the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   assign tok_out = tok_ff;
   assign delta   = delta_ff;
   assign tag     = tag_ff;

endmodule

`default_nettype wire

// ===== sv/delta_list_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue_top: timer queue kept as a delta list
// Posts insert a tagged delay into a row of cells ordered by deadline; gets
// deliver the head once due and report the delay until the next deadline.
//
//   channel   ports                              handshake
//   request   req_mode .. req_message_tag        start & !busy
//   response  rsp_status .. rsp_next_none        rsp_valid, one cycle
//
// A post keeps busy high through the time, dispatch and walk states: the
// insertion word visits one cell per cycle up to the tail of the list.
// A full post or a get on an empty queue ends at dispatch; other gets add a check.
// The response appears in the same cycle that busy falls, for one cycle only.
// Synchronous reset empties the queue and clears the reference time.
// The receiver cannot stall; a new request may be given while a response shows.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_timer_queue_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire                req_mode,
   input  wire  [31:0]        req_now_ms,
   input  wire  [30:0]        req_delay_ms,
   input  wire                req_delay_none,
   input  wire  [31:0]        req_message_tag,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_out_tag,
   output logic signed [31:0] rsp_next_delay,
   output logic               rsp_next_none
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_TIME   = 5'b00010,
      S_DISP   = 5'b00100,
      S_WALK   = 5'b01000,
      S_GETCHK = 5'b10000
   } state_type;

   state_type                      state_ff, state_in;
   logic [dltq_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [dltq_pkg::CNT_W-1:0]     walk_ff, walk_in;
   logic [31:0]                    ref_time_ff, ref_time_in;
   logic                           ref_valid_ff, ref_valid_in;
   logic                           mode_ff, mode_in;
   logic [31:0]                    now_ff, now_in;
   logic [30:0]                    delay_ff, delay_in;
   logic                           none_ff, none_in;
   logic [31:0]                    mtag_ff, mtag_in;
   logic [31:0]                    elapsed_ff, elapsed_in;
   logic [31:0]                    over_ff, over_in;
   dltq_pkg::tok_type              tok_ff, tok_in;
   logic                           pop_en;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [31:0]                    rsp_tag_ff, rsp_tag_in;
   logic [31:0]                    rsp_delay_ff, rsp_delay_in;
   logic                           rsp_none_ff, rsp_none_in;

   dltq_pkg::tok_type              tok_chain [dltq_pkg::QUEUE_DEPTH+1];
   logic [31:0]                    cell_delta [dltq_pkg::QUEUE_DEPTH];
   logic [31:0]                    cell_tag   [dltq_pkg::QUEUE_DEPTH];
   logic [31:0]                    pop_delta  [dltq_pkg::QUEUE_DEPTH];
   logic [31:0]                    pop_tag    [dltq_pkg::QUEUE_DEPTH];
   logic [31:0]                    head_next;

   // new head delta after a pop, charged with the overshoot
   assign head_next = cell_delta[1] - over_ff;

   // row of cells
   assign tok_chain[0] = tok_ff;
   for (genvar i = 0; i < dltq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign pop_delta[i] = head_next;
      end else if (i < dltq_pkg::QUEUE_DEPTH - 1) begin : g_mid
         assign pop_delta[i] = cell_delta[i+1];
      end else begin : g_last
         assign pop_delta[i] = cell_delta[i];
      end
      if (i < dltq_pkg::QUEUE_DEPTH - 1) begin : g_tag_nb
         assign pop_tag[i] = cell_tag[i+1];
      end else begin : g_tag_last
         assign pop_tag[i] = cell_tag[i];
      end
      dltq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .occ       (count_ff > dltq_pkg::CNT_W'(i)),
         .tok_in    (tok_chain[i]),
         .tok_out   (tok_chain[i+1]),
         .pop_en    (pop_en),
         .pop_delta (pop_delta[i]),
         .pop_tag   (pop_tag[i]),
         .delta     (cell_delta[i]),
         .tag       (cell_tag[i])
      );
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      ref_time_in   = ref_time_ff;
      ref_valid_in  = ref_valid_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      delay_in      = delay_ff;
      none_in       = none_ff;
      mtag_in       = mtag_ff;
      elapsed_in    = elapsed_ff;
      over_in       = over_ff;
      tok_in        = '0;
      pop_en        = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_none_in   = rsp_none_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               now_in   = req_now_ms;
               delay_in = req_delay_ms;
               none_in  = req_delay_none;
               mtag_in  = req_message_tag;
               state_in = S_TIME;
            end
         end
         S_TIME: begin
            elapsed_in = ref_valid_ff ? (now_ff - ref_time_ff) : 32'd0;
            state_in   = S_DISP;
         end
         S_DISP: begin
            rsp_tag_in   = 32'd0;
            rsp_delay_in = 32'd0;
            rsp_none_in  = 1'b0;
            if (!mode_ff) begin
               if (count_ff == dltq_pkg::CNT_W'(dltq_pkg::QUEUE_DEPTH)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = dltq_pkg::ST_FULL;
                  state_in      = S_IDLE;
               end else begin
                  // launch the insertion word
                  tok_in.valid  = 1'b1;
                  tok_in.append = none_ff;
                  tok_in.delta  = none_ff ? 32'd0 : ({1'b0, delay_ff} + elapsed_ff);
                  tok_in.tag    = mtag_ff;
                  walk_in       = '0;
                  if (!ref_valid_ff) begin
                     ref_time_in  = now_ff;
                     ref_valid_in = 1'b1;
                  end
                  state_in = S_WALK;
               end
            end else if (count_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = dltq_pkg::ST_IDLE;
               rsp_delay_in  = 32'd1;
               state_in      = S_IDLE;
            end else begin
               over_in  = elapsed_ff - cell_delta[0];
               state_in = S_GETCHK;
            end
         end
         S_WALK: begin
            // word sits at cell walk_ff this cycle
            walk_in = walk_ff + 1'b1;
            if (walk_ff == count_ff) begin
               count_in      = count_ff + 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = dltq_pkg::ST_POSTED;
               state_in      = S_IDLE;
            end
         end
         S_GETCHK: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (over_ff[31]) begin
               rsp_status_in = dltq_pkg::ST_IDLE;
               rsp_delay_in  = 32'd0 - over_ff;
            end else begin
               pop_en        = 1'b1;
               count_in      = count_ff - 1'b1;
               rsp_status_in = dltq_pkg::ST_DELIVER;
               rsp_tag_in    = cell_tag[0];
               if (count_ff > dltq_pkg::CNT_W'(1)) begin
                  rsp_delay_in = head_next;
                  ref_time_in  = now_ff;
               end else begin
                  rsp_none_in  = 1'b1;
                  ref_valid_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ref_time_ff  <= 32'd0;
         ref_valid_ff <= 1'b0;
         tok_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ref_time_ff  <= ref_time_in;
         ref_valid_ff <= ref_valid_in;
         tok_ff       <= tok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      mode_ff       <= mode_in;
      now_ff        <= now_in;
      delay_ff      <= delay_in;
      none_ff       <= none_in;
      mtag_ff       <= mtag_in;
      elapsed_ff    <= elapsed_in;
      over_ff       <= over_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_none_ff   <= rsp_none_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_tag    = rsp_tag_ff;
   assign rsp_next_delay = rsp_delay_ff;
   assign rsp_next_none  = rsp_none_ff;

`ifndef SYNTH
   // insertion word never runs off the end of the row
   a_tok_end: assert property (@(posedge clock) disable iff (reset)
      !tok_chain[dltq_pkg::QUEUE_DEPTH].valid)
      else $error("insertion word left the last cell");

   // fill count stays within the row
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dltq_pkg::CNT_W'(dltq_pkg::QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   // a response is shown only once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // an accepted word always raises busy
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word without busy");
`endif

endmodule

`default_nettype wire
